// ----- rtl/skt_pkg.sv -----
`default_nettype none

package skt_pkg;

  // Default sizes of the table
  localparam int TABLE_DEPTH_DEF = 16;
  localparam int DATE_BITS_DEF   = 32;
  localparam int ID_BITS_DEF     = 16;

  // Request codes
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NOT_FOUND = 2'd2
  } skt_status_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CHK,
    ST_REM_RD,
    ST_REM_CHK,
    ST_SHF_RD,
    ST_SHF_WR,
    ST_HEAD_RD,
    ST_HEAD_CHK
  } skt_state_t;

endpackage

`default_nettype wire

// ----- rtl/skt_ram.sv -----
`default_nettype none

module skt_ram #(
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4,
  parameter int WORD_W = 48
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WORD_W-1:0] wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output      logic [WORD_W-1:0] rdata
);

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/sorted_key_table.sv -----
// Sorted key table: holds up to TABLE_DEPTH (date, id) entries in ascending
// date order in a single-port-read, single-port-write RAM, walked one entry
// per step by a small sequencer. An insert moves every entry whose date is
// not less than the new one up by one slot, starting from the tail, and
// writes the new entry into the gap, so it lands ahead of equal dates. A
// remove scans from the head for the first matching id, then moves every
// later entry down by one slot. Each entry read is split into issuing the
// read and then using the registered read data. An insert into a full
// table goes straight to the head read. The in channel stalls from the
// accepting edge until the result is loaded, including any wait on a
// stalled earlier beat; the result beat sits in an output register, so the
// next request is taken while it waits. Every result beat reports the
// status, the removed date (zero unless a remove succeeded), the count
// after the request and the head entry (zero when the table is empty). The
// RAM needs no clearing after reset: slots at or above the count are never
// used, as the head read of an empty table is masked to zero.
`default_nettype none

module sorted_key_table import skt_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int DATE_BITS   = DATE_BITS_DEF,
  parameter int ID_BITS     = ID_BITS_DEF,
  localparam int CNT_W      = $clog2(TABLE_DEPTH + 1)
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // request channel
  input  wire logic                 in_valid,
  output      logic                 in_stall,
  input  wire logic                 req_type,
  input  wire logic [DATE_BITS-1:0] key_date,
  input  wire logic [ID_BITS-1:0]   item_id,
  // result channel
  output      logic                 out_valid,
  input  wire logic                 out_stall,
  output      logic [1:0]           status,
  output      logic [DATE_BITS-1:0] removed_date,
  output      logic [CNT_W-1:0]     entry_count,
  output      logic                 head_valid,
  output      logic [DATE_BITS-1:0] head_date,
  output      logic [ID_BITS-1:0]   head_id
);

  localparam int IDX_W  = $clog2(TABLE_DEPTH);
  localparam int WORD_W = DATE_BITS + ID_BITS;

  skt_state_t state, state_next;

  // request context and table bookkeeping
  logic [CNT_W-1:0]     ptr, ptr_next;
  logic [CNT_W-1:0]     count, count_next;
  logic [DATE_BITS-1:0] req_date, req_date_next;
  logic [ID_BITS-1:0]   req_id, req_id_next;
  skt_status_t          req_stat, req_stat_next;
  logic [DATE_BITS-1:0] req_rdate, req_rdate_next;

  // RAM port
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic [IDX_W-1:0]  mem_raddr;
  logic [WORD_W-1:0] mem_rdata;

  logic [DATE_BITS-1:0] rd_date;
  logic [ID_BITS-1:0]   rd_id;
  logic                 in_accept;
  logic                 out_load;
  logic                 table_full;
  logic                 ptr_at_zero;
  logic                 ptr_at_count;
  logic                 ptr_last;

  assign rd_date = mem_rdata[WORD_W-1:ID_BITS];
  assign rd_id   = mem_rdata[ID_BITS-1:0];

  assign in_stall     = (state != ST_IDLE);
  assign in_accept    = in_valid && !in_stall;
  // hold the finished result while the previous beat is still stalled
  assign out_load     = (state == ST_HEAD_CHK) && !(out_valid && out_stall);
  assign table_full   = (count == CNT_W'(TABLE_DEPTH));
  assign ptr_at_zero  = (ptr == '0);
  assign ptr_at_count = (ptr == count);
  assign ptr_last     = ((ptr + CNT_W'(1)) == count);

  skt_ram #(
    .DEPTH  (TABLE_DEPTH),
    .ADDR_W (IDX_W),
    .WORD_W (WORD_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_accept) begin
          if (req_type == REQ_REMOVE) begin
            state_next = ST_REM_RD;
          end else if (table_full) begin
            state_next = ST_HEAD_RD;
          end else begin
            state_next = ST_INS_RD;
          end
        end
      end
      ST_INS_RD:   state_next = ptr_at_zero ? ST_HEAD_RD : ST_INS_CHK;
      ST_INS_CHK:  state_next = (rd_date >= req_date) ? ST_INS_RD : ST_HEAD_RD;
      ST_REM_RD:   state_next = ptr_at_count ? ST_HEAD_RD : ST_REM_CHK;
      ST_REM_CHK:  state_next = (rd_id == req_id) ? ST_SHF_RD : ST_REM_RD;
      ST_SHF_RD:   state_next = ptr_last ? ST_HEAD_RD : ST_SHF_WR;
      ST_SHF_WR:   state_next = ST_SHF_RD;
      ST_HEAD_RD:  state_next = ST_HEAD_CHK;
      ST_HEAD_CHK: state_next = out_load ? ST_IDLE : ST_HEAD_CHK;
      default:     state_next = ST_IDLE;
    endcase
  end

  // Datapath and RAM control
  always_comb begin
    ptr_next       = ptr;
    count_next     = count;
    req_date_next  = req_date;
    req_id_next    = req_id;
    req_stat_next  = req_stat;
    req_rdate_next = req_rdate;
    mem_we         = 1'b0;
    mem_waddr      = ptr[IDX_W-1:0];
    mem_wdata      = {req_date, req_id};
    mem_raddr      = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_accept) begin
          req_date_next  = key_date;
          req_id_next    = item_id;
          req_rdate_next = '0;
          req_stat_next  = STAT_OK;
          if (req_type == REQ_REMOVE) begin
            ptr_next = '0;
          end else begin
            // insert walks down from the tail slot
            ptr_next = count;
            if (table_full) begin
              req_stat_next = STAT_FULL;
            end
          end
        end
      end
      ST_INS_RD: begin
        if (ptr_at_zero) begin
          mem_we     = 1'b1;
          count_next = count + CNT_W'(1);
        end else begin
          mem_raddr = IDX_W'(ptr - CNT_W'(1));
        end
      end
      ST_INS_CHK: begin
        mem_we = 1'b1;
        if (rd_date >= req_date) begin
          // move the entry up one slot and keep walking
          mem_wdata = mem_rdata;
          ptr_next  = ptr - CNT_W'(1);
        end else begin
          count_next = count + CNT_W'(1);
        end
      end
      ST_REM_RD: begin
        if (ptr_at_count) begin
          req_stat_next = STAT_NOT_FOUND;
        end else begin
          mem_raddr = ptr[IDX_W-1:0];
        end
      end
      ST_REM_CHK: begin
        if (rd_id == req_id) begin
          req_rdate_next = rd_date;
        end else begin
          ptr_next = ptr + CNT_W'(1);
        end
      end
      ST_SHF_RD: begin
        if (ptr_last) begin
          count_next = count - CNT_W'(1);
        end else begin
          mem_raddr = IDX_W'(ptr + CNT_W'(1));
        end
      end
      ST_SHF_WR: begin
        // close the gap: move the next entry down one slot
        mem_we    = 1'b1;
        mem_wdata = mem_rdata;
        ptr_next  = ptr + CNT_W'(1);
      end
      ST_HEAD_RD,
      ST_HEAD_CHK: begin
        mem_raddr = '0;
      end
      default: begin
        mem_raddr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    ptr       <= ptr_next;
    req_date  <= req_date_next;
    req_id    <= req_id_next;
    req_stat  <= req_stat_next;
    req_rdate <= req_rdate_next;
  end

  // Result register: load when done, drop after the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status       <= req_stat;
      removed_date <= req_rdate;
      entry_count  <= count;
      head_valid   <= (count != '0);
      head_date    <= (count != '0) ? rd_date : '0;
      head_id      <= (count != '0) ? rd_id : '0;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/skt_checker.sv -----
`default_nettype none

module skt_checker import skt_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int DATE_BITS   = DATE_BITS_DEF,
  parameter int ID_BITS     = ID_BITS_DEF,
  localparam int CNT_W      = $clog2(TABLE_DEPTH + 1)
) (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 out_valid,
  input wire logic                 out_stall,
  input wire logic [1:0]           status,
  input wire logic [DATE_BITS-1:0] removed_date,
  input wire logic [CNT_W-1:0]     entry_count,
  input wire logic                 head_valid,
  input wire logic [DATE_BITS-1:0] head_date,
  input wire logic [ID_BITS-1:0]   head_id
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(entry_count))
    else $error("result beat changed while stalled");

  a_head_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (head_valid == (entry_count != '0)))
    else $error("head_valid disagrees with entry_count");

  a_empty_head: assert property (@(posedge clk) disable iff (rst)
    out_valid && !head_valid |-> (head_date == '0) && (head_id == '0))
    else $error("empty table reports a nonzero head");

  a_fail_date: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != STAT_OK) |-> (removed_date == '0))
    else $error("failed request reports a removed date");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STAT_FULL) |-> (entry_count == CNT_W'(TABLE_DEPTH)))
    else $error("full status with a table that is not full");

endmodule

bind sorted_key_table skt_checker #(
  .TABLE_DEPTH (TABLE_DEPTH),
  .DATE_BITS   (DATE_BITS),
  .ID_BITS     (ID_BITS)
) u_skt_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .status       (status),
  .removed_date (removed_date),
  .entry_count  (entry_count),
  .head_valid   (head_valid),
  .head_date    (head_date),
  .head_id      (head_id)
);

`default_nettype wire
